### rtl/assert_macros.svh
// Assertion macros shared by the classifier RTL.
// Each macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check.
`define SFPC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Same-cycle implication check.
`define SFPC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### rtl/sfpc_pkg.sv
`default_nettype none
// Shared types, codes and the fixed pattern table of the flow classifier.
// No dependencies.
package sfpc_pkg;

    typedef struct packed {
        logic [7:0] char_code;
        logic       carries_char;
        logic [1:0] action;
        logic       field_start;
        logic       already_stream;
        logic       end_of_flow;
    } t_in_req;

    typedef struct packed {
        logic       is_stream;
        logic [2:0] stream_kind;
        logic       live_flag;
        logic       service_known;
    } t_out_res;

    // Sticky pattern groups; one bit per group that the decision looks at.
    typedef struct packed {
        logic host;
        logic media;
        logic live;
        logic rtc;
        logic chunk_host;
        logic chunk_url;
        logic dash;
        logic hls;
    } t_hits;

    localparam logic [1:0] FIELD_URL   = 2'd0;
    localparam logic [1:0] FIELD_HOST  = 2'd1;
    localparam logic [1:0] FIELD_CTYPE = 2'd2;
    localparam logic [1:0] FIELD_HDR   = 2'd3;

    localparam logic [2:0] KIND_NONE   = 3'd0;
    localparam logic [2:0] KIND_HLS    = 3'd1;
    localparam logic [2:0] KIND_DASH   = 3'd2;
    localparam logic [2:0] KIND_CHUNK  = 3'd3;
    localparam logic [2:0] KIND_RTC    = 3'd4;
    localparam logic [2:0] KIND_MEDIA  = 3'd5;
    localparam logic [2:0] KIND_TAGGED = 3'd6;

    localparam logic [7:0] HIT_HLS    = 8'b0000_0001;
    localparam logic [7:0] HIT_DASH   = 8'b0000_0010;
    localparam logic [7:0] HIT_CURL   = 8'b0000_0100;
    localparam logic [7:0] HIT_CHOST  = 8'b0000_1000;
    localparam logic [7:0] HIT_RTC    = 8'b0001_0000;
    localparam logic [7:0] HIT_LIVE   = 8'b0010_0000;
    localparam logic [7:0] HIT_MEDIA  = 8'b0100_0000;
    localparam logic [7:0] HIT_HOST   = 8'b1000_0000;

    localparam int NUM_PATS    = 45;
    localparam int PAT_MAX_LEN = 15;
    localparam int PAT_BITS    = 8 * PAT_MAX_LEN;

    // Pattern bytes in reading order; the last character sits in byte 0 so
    // that byte k lines up with the k-th newest byte of the window.
    localparam logic [PAT_BITS-1:0] PAT_TEXT [NUM_PATS] = '{
        120'h2e6d337538,
        120'h2e6d7064,
        120'h766964656f706c61796261636b,
        120'h7374756e,
        120'h7475726e3a,
        120'h2f776562727463,
        120'h6c697665,
        120'h2f686c732f,
        120'h2f646173682f,
        120'h6368756e6b6c697374,
        120'h6c69766573747265616d,
        120'h2e7473,
        120'h2e6d7034,
        120'h2e616163,
        120'h2e7765626d,
        120'h7365676d656e74,
        120'h6d70656775726c,
        120'h646173682b786d6c,
        120'h766964656f,
        120'h617564696f,
        120'h696365,
        120'h676f6f676c65766964656f2e636f6d,
        120'h796f75747562652e636f6d,
        120'h796f7574752e6265,
        120'h6e666c78766964656f2e6e6574,
        120'h6e6574666c69782e636f6d,
        120'h7477697463682e7476,
        120'h7477697463687376632e6e6574,
        120'h6a74766e772e6e6574,
        120'h68756c752e636f6d,
        120'h68756c7573747265616d2e636f6d,
        120'h6469736e6579706c75732e636f6d,
        120'h62616d677269642e636f6d,
        120'h7072696d65766964656f2e636f6d,
        120'h6169762d63646e2e6e6574,
        120'h73706f746966792e636f6d,
        120'h7363646e2e636f,
        120'h736f756e64636c6f75642e636f6d,
        120'h736e6463646e2e636f6d,
        120'h76696d656f2e636f6d,
        120'h76696d656f63646e2e636f6d,
        120'h6461696c796d6f74696f6e2e636f6d,
        120'h646d63646e2e6e6574,
        120'h616b616d616968642e6e6574,
        120'h666173746c792e6e6574
    };

    localparam logic [3:0] PAT_LEN [NUM_PATS] = '{
        4'd5,  4'd4,  4'd13, 4'd4,  4'd5,  4'd7,  4'd4,  4'd5,  4'd6,  4'd9,
        4'd10, 4'd3,  4'd4,  4'd4,  4'd5,  4'd7,  4'd7,  4'd8,  4'd5,  4'd5,
        4'd3,  4'd15, 4'd11, 4'd8,  4'd13, 4'd11, 4'd9,  4'd13, 4'd9,  4'd8,
        4'd14, 4'd14, 4'd11, 4'd14, 4'd11, 4'd11, 4'd7,  4'd14, 4'd10, 4'd9,
        4'd12, 4'd15, 4'd9,  4'd12, 4'd10
    };

    localparam logic [1:0] PAT_FIELD [NUM_PATS] = '{
        FIELD_URL,   FIELD_URL,   FIELD_URL,   FIELD_URL,   FIELD_URL,
        FIELD_URL,   FIELD_URL,   FIELD_URL,   FIELD_URL,   FIELD_URL,
        FIELD_URL,   FIELD_URL,   FIELD_URL,   FIELD_URL,   FIELD_URL,
        FIELD_URL,   FIELD_CTYPE, FIELD_CTYPE, FIELD_CTYPE, FIELD_CTYPE,
        FIELD_HDR,   FIELD_HOST,  FIELD_HOST,  FIELD_HOST,  FIELD_HOST,
        FIELD_HOST,  FIELD_HOST,  FIELD_HOST,  FIELD_HOST,  FIELD_HOST,
        FIELD_HOST,  FIELD_HOST,  FIELD_HOST,  FIELD_HOST,  FIELD_HOST,
        FIELD_HOST,  FIELD_HOST,  FIELD_HOST,  FIELD_HOST,  FIELD_HOST,
        FIELD_HOST,  FIELD_HOST,  FIELD_HOST,  FIELD_HOST,  FIELD_HOST
    };

    // The first host pattern also names the service for the chunk rule.
    localparam logic [7:0] PAT_HITS [NUM_PATS] = '{
        HIT_HLS,   HIT_DASH,  HIT_CURL,  HIT_RTC,   HIT_RTC,
        HIT_RTC,   HIT_LIVE,  HIT_LIVE,  HIT_LIVE,  HIT_LIVE,
        HIT_LIVE,  HIT_MEDIA, HIT_MEDIA, HIT_MEDIA, HIT_MEDIA,
        HIT_MEDIA, HIT_HLS,   HIT_DASH,  HIT_MEDIA, HIT_MEDIA,
        HIT_RTC,   HIT_HOST | HIT_CHOST,
        HIT_HOST,  HIT_HOST,  HIT_HOST,  HIT_HOST,  HIT_HOST,
        HIT_HOST,  HIT_HOST,  HIT_HOST,  HIT_HOST,  HIT_HOST,
        HIT_HOST,  HIT_HOST,  HIT_HOST,  HIT_HOST,  HIT_HOST,
        HIT_HOST,  HIT_HOST,  HIT_HOST,  HIT_HOST,  HIT_HOST,
        HIT_HOST,  HIT_HOST,  HIT_HOST
    };

endpackage

`default_nettype wire

### rtl/sfpc_window.sv
`default_nettype none
// Byte window of the current text field with its fill count.
// No package dependency; the fill width follows WINDOW_LEN only.
module sfpc_window #(
    parameter int WINDOW_LEN = 15
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_take,
    input  wire                         i_field_start,
    input  wire                         i_carries,
    input  wire  [7:0]                  i_char,
    output logic [WINDOW_LEN-1:0][7:0]  o_window,
    output logic [$clog2(WINDOW_LEN+1)-1:0] o_fill
);

    localparam int FW = $clog2(WINDOW_LEN + 1);
    localparam logic [FW-1:0] FILL_MAX = FW'(WINDOW_LEN);

    logic [WINDOW_LEN-1:0][7:0] r_window;
    logic [WINDOW_LEN-1:0][7:0] n_window;
    logic [FW-1:0]              r_fill;
    logic [FW-1:0]              n_fill;
    logic [FW-1:0]              fill_base;
    logic [7:0]                 lc_char;

    always_comb begin
        lc_char = i_char;
        if (i_char >= 8'h41 && i_char <= 8'h5a) begin
            lc_char = i_char + 8'h20;
        end
        fill_base = i_field_start ? '0 : r_fill;
        n_window  = r_window;
        n_fill    = fill_base;
        if (i_carries) begin
            n_window = {r_window[WINDOW_LEN-2:0], lc_char};
            if (fill_base != FILL_MAX) begin
                n_fill = fill_base + 1'b1;
            end
        end
    end

    // Bytes above the fill count are never compared, so the window needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_window <= n_window;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_take) begin
            r_fill <= n_fill;
        end
    end

    assign o_window = n_window;
    assign o_fill   = n_fill;

endmodule

`default_nettype wire

### rtl/sfpc_match.sv
`default_nettype none
// Parallel suffix comparators: every fixed pattern against the newest bytes.
// Depends on sfpc_pkg for the pattern table and the group struct.
module sfpc_match #(
    parameter int WINDOW_LEN = 15
) (
    input  wire  [WINDOW_LEN-1:0][7:0]       i_window,
    input  wire  [$clog2(WINDOW_LEN+1)-1:0]  i_fill,
    input  wire  [1:0]                       i_field,
    input  wire                              i_carries,
    output sfpc_pkg::t_hits                  o_hits
);

    localparam int FW = $clog2(WINDOW_LEN + 1);

    logic [7:0] hits_v;

    always_comb begin
        logic hit;
        hits_v = '0;
        for (int p = 0; p < sfpc_pkg::NUM_PATS; p++) begin
            hit = i_carries && (i_field == sfpc_pkg::PAT_FIELD[p])
                && (i_fill >= FW'(sfpc_pkg::PAT_LEN[p]));
            for (int k = 0; k < sfpc_pkg::PAT_MAX_LEN; k++) begin
                if (k < int'(sfpc_pkg::PAT_LEN[p])
                        && i_window[k] != sfpc_pkg::PAT_TEXT[p][8*k +: 8]) begin
                    hit = 1'b0;
                end
            end
            if (hit) begin
                hits_v = hits_v | sfpc_pkg::PAT_HITS[p];
            end
        end
    end

    assign o_hits = sfpc_pkg::t_hits'(hits_v);

endmodule

`default_nettype wire

### rtl/sfpc_classify.sv
`default_nettype none
// Sticky group flags, end-of-flow priority decision and the result register.
// Depends on sfpc_pkg and assert_macros.svh.
`include "assert_macros.svh"
module sfpc_classify (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_take,
    input  wire                 i_eof,
    input  wire                 i_tagged,
    input  sfpc_pkg::t_hits     i_hits,
    input  wire                 i_out_stall,
    output logic                o_ready,
    output logic                o_out_valid,
    output sfpc_pkg::t_out_res  o_out_res
);

    sfpc_pkg::t_hits    r_flags;
    sfpc_pkg::t_hits    n_flags;
    sfpc_pkg::t_hits    f;
    sfpc_pkg::t_out_res r_out;
    sfpc_pkg::t_out_res n_out;
    sfpc_pkg::t_out_res res;
    logic               r_out_valid;
    logic               n_out_valid;
    logic [2:0]         kind;

    always_comb begin
        f = r_flags | i_hits;
        if (f.hls) begin
            kind = sfpc_pkg::KIND_HLS;
        end else if (f.dash) begin
            kind = sfpc_pkg::KIND_DASH;
        end else if (f.chunk_host && f.chunk_url) begin
            kind = sfpc_pkg::KIND_CHUNK;
        end else if (f.rtc) begin
            kind = sfpc_pkg::KIND_RTC;
        end else if (f.host && f.media) begin
            kind = sfpc_pkg::KIND_MEDIA;
        end else begin
            kind = sfpc_pkg::KIND_NONE;
        end

        if (i_tagged) begin
            res.is_stream     = 1'b1;
            res.stream_kind   = sfpc_pkg::KIND_TAGGED;
            res.live_flag     = 1'b0;
            res.service_known = 1'b0;
        end else begin
            res.is_stream     = (kind != sfpc_pkg::KIND_NONE);
            res.stream_kind   = kind;
            res.live_flag     = (kind != sfpc_pkg::KIND_NONE) && f.live;
            res.service_known = (kind == sfpc_pkg::KIND_CHUNK);
        end

        n_flags     = r_flags;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        if (i_take) begin
            if (i_eof) begin
                // Drop the flags for the next flow and load the result.
                n_flags     = '0;
                n_out       = res;
                n_out_valid = 1'b1;
            end else begin
                n_flags = f;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_flags     <= n_flags;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_ready     = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out;

    `SFPC_ASSERT_IMPL(a_res_from_eof, (r_out_valid && !$past(r_out_valid)), $past(i_take && i_eof), "result appeared without an end of flow")
    `SFPC_ASSERT_IMPL(a_flags_cleared, $past(i_take && i_eof), (r_flags == '0), "match flags kept across end of flow")
    `SFPC_ASSERT_IMPL(a_svc_chunk, r_out_valid, (r_out.service_known == (r_out.stream_kind == sfpc_pkg::KIND_CHUNK)), "service flag out of step with kind")

endmodule

`default_nettype wire

### rtl/stream_flow_pattern_classifier.sv
`default_nettype none
// Stream flow pattern classifier, top level.
// Input channel: i_in_valid / o_in_stall carry one request per byte of a flow's
// URL, host, content type and header fields; field_start marks a field's first
// request and end_of_flow its last. Output channel: o_out_valid / i_out_stall
// carry one result per end_of_flow request, nothing for the other requests.
// A request accepted into the input register is matched and decided from there;
// its result is loaded into the result register when that request is taken.
// Throughput: one request per cycle while no end_of_flow request waits, set by the
// single pass through the window comparators from input to result register.
// When the receiver stalls, the held result stays; byte requests keep flowing,
// and only an end_of_flow request waits in the input register, which stalls
// the sender for as long as the result cannot leave.
// Reset (synchronous, active low) empties both registers, the window fill
// and the match flags; no clearing pass is needed.
// Depends on sfpc_pkg, sfpc_window, sfpc_match, sfpc_classify, assert_macros.svh.
`include "assert_macros.svh"
module stream_flow_pattern_classifier #(
    parameter int WINDOW_LEN = 15
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  sfpc_pkg::t_in_req   i_in_req,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output sfpc_pkg::t_out_res  o_out_res
);

    localparam int FW = $clog2(WINDOW_LEN + 1);

    logic                       r_in_valid;
    logic                       n_in_valid;
    sfpc_pkg::t_in_req          r_in;
    logic                       accept;
    logic                       take;
    logic                       res_ready;
    logic [WINDOW_LEN-1:0][7:0] window;
    logic [FW-1:0]              fill;
    sfpc_pkg::t_hits            hits;

    // An end-of-flow request advances only when the result register frees up.
    assign take       = r_in_valid && (!r_in.end_of_flow || res_ready);
    assign o_in_stall = r_in_valid && !take;
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (accept) begin
            n_in_valid = 1'b1;
        end else if (take) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_in_req;
        end
    end

    sfpc_window #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_window (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (take),
        .i_field_start (r_in.field_start),
        .i_carries     (r_in.carries_char),
        .i_char        (r_in.char_code),
        .o_window      (window),
        .o_fill        (fill)
    );

    sfpc_match #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_match (
        .i_window  (window),
        .i_fill    (fill),
        .i_field   (r_in.action),
        .i_carries (r_in.carries_char),
        .o_hits    (hits)
    );

    sfpc_classify u_classify (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_eof       (r_in.end_of_flow),
        .i_tagged    (r_in.already_stream),
        .i_hits      (hits),
        .i_out_stall (i_out_stall),
        .o_ready     (res_ready),
        .o_out_valid (o_out_valid),
        .o_out_res   (o_out_res)
    );

    `SFPC_ASSERT_IMPL(a_stall_cause, o_in_stall, (r_in.end_of_flow && i_out_stall && o_out_valid), "input stalled without a blocked result")

endmodule

`default_nettype wire

### dv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for stream_flow_pattern_classifier: directed flows, then random
// flows and noise under idling, stalling and back-pressure. Needs sfpc_pkg and the RTL.
module testbench;

    localparam int WIN    = 15;
    localparam int NPAT   = 45;
    localparam int PERIOD = 12;

    // Pattern text, right-aligned: the last character sits in byte 0.
    localparam logic [119:0] PTXT [NPAT] = '{
        120'h2e6d337538,                     // .m3u8
        120'h2e6d7064,                       // .mpd
        120'h766964656f706c61796261636b,     // videoplayback
        120'h7374756e,                       // stun
        120'h7475726e3a,                     // turn:
        120'h2f776562727463,                 // /webrtc
        120'h6c697665,                       // live
        120'h2f686c732f,                     // /hls/
        120'h2f646173682f,                   // /dash/
        120'h6368756e6b6c697374,             // chunklist
        120'h6c69766573747265616d,           // livestream
        120'h2e7473,                         // .ts
        120'h2e6d7034,                       // .mp4
        120'h2e616163,                       // .aac
        120'h2e7765626d,                     // .webm
        120'h7365676d656e74,                 // segment
        120'h6d70656775726c,                 // mpegurl
        120'h646173682b786d6c,               // dash+xml
        120'h766964656f,                     // video
        120'h617564696f,                     // audio
        120'h696365,                         // ice
        // host names of known media services
        120'h676f6f676c65766964656f2e636f6d,
        120'h796f75747562652e636f6d,
        120'h796f7574752e6265,
        120'h6e666c78766964656f2e6e6574,
        120'h6e6574666c69782e636f6d,
        120'h7477697463682e7476,
        120'h7477697463687376632e6e6574,
        120'h6a74766e772e6e6574,
        120'h68756c752e636f6d,
        120'h68756c7573747265616d2e636f6d,
        120'h6469736e6579706c75732e636f6d,
        120'h62616d677269642e636f6d,
        120'h7072696d65766964656f2e636f6d,
        120'h6169762d63646e2e6e6574,
        120'h73706f746966792e636f6d,
        120'h7363646e2e636f,
        120'h736f756e64636c6f75642e636f6d,
        120'h736e6463646e2e636f6d,
        120'h76696d656f2e636f6d,
        120'h76696d656f63646e2e636f6d,
        120'h6461696c796d6f74696f6e2e636f6d,
        120'h646d63646e2e6e6574,
        120'h616b616d616968642e6e6574,
        120'h666173746c792e6e6574
    };

    localparam int HOST_BASE = 21;
    localparam int CHUNK_HOST_PAT = 21;
    localparam int CHUNK_URL_PAT  = 2;

    localparam logic [NPAT-1:0] ONE        = 45'd1;
    localparam logic [NPAT-1:0] HLS_MASK   = (ONE << 0) | (ONE << 16);
    localparam logic [NPAT-1:0] DASH_MASK  = (ONE << 1) | (ONE << 17);
    localparam logic [NPAT-1:0] RTC_MASK   = (ONE << 3) | (ONE << 4) | (ONE << 5) | (ONE << 20);
    localparam logic [NPAT-1:0] LIVE_MASK  = (ONE << 6) | (ONE << 7) | (ONE << 8) | (ONE << 9)
                                           | (ONE << 10);
    localparam logic [NPAT-1:0] MEDIA_MASK = (ONE << 11) | (ONE << 12) | (ONE << 13)
                                           | (ONE << 14) | (ONE << 15) | (ONE << 18)
                                           | (ONE << 19);
    localparam logic [NPAT-1:0] HOST_MASK  = {NPAT{1'b1}} << HOST_BASE;

    logic               i_clk;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    sfpc_pkg::t_in_req  i_in_req    = '0;
    logic               i_out_stall = 1'b0;
    logic               o_in_stall;
    logic               o_out_valid;
    sfpc_pkg::t_out_res o_out_res;

    // Classifier state as the block should hold it
    logic [7:0]         win_bytes [WIN];
    int                 win_fill = 0;
    logic [NPAT-1:0]    hit_flags = '0;
    sfpc_pkg::t_out_res pending_results [$];

    int errors         = 0;
    int sent_count     = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;
    sfpc_pkg::t_out_res got_want;

    stream_flow_pattern_classifier #(
        .WINDOW_LEN(WIN)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_res   (o_out_res)
    );

    initial begin
        i_clk = 1'b0;
        forever #(PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("%0t: timeout with %0d results pending", $time, pending_results.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic int pat_len(input int i);
        int n;
        n = 0;
        while (n < WIN && PTXT[i][8*n +: 8] != 8'h00) n++;
        return n;
    endfunction

    function automatic logic [1:0] pat_field(input int i);
        if (i < 16) return sfpc_pkg::FIELD_URL;
        if (i < 20) return sfpc_pkg::FIELD_CTYPE;
        if (i == 20) return sfpc_pkg::FIELD_HDR;
        return sfpc_pkg::FIELD_HOST;
    endfunction

    function automatic sfpc_pkg::t_out_res classify_flags(input logic prior_tag,
                                                          input logic [NPAT-1:0] f);
        sfpc_pkg::t_out_res res;
        res = '0;
        if (prior_tag) begin
            res.is_stream   = 1'b1;
            res.stream_kind = sfpc_pkg::KIND_TAGGED;
        end else begin
            if ((f & HLS_MASK) != 0)
                res.stream_kind = sfpc_pkg::KIND_HLS;
            else if ((f & DASH_MASK) != 0)
                res.stream_kind = sfpc_pkg::KIND_DASH;
            else if (f[CHUNK_HOST_PAT] && f[CHUNK_URL_PAT])
                res.stream_kind = sfpc_pkg::KIND_CHUNK;
            else if ((f & RTC_MASK) != 0)
                res.stream_kind = sfpc_pkg::KIND_RTC;
            else if ((f & HOST_MASK) != 0 && (f & MEDIA_MASK) != 0)
                res.stream_kind = sfpc_pkg::KIND_MEDIA;
            if (res.stream_kind != sfpc_pkg::KIND_NONE) begin
                res.is_stream     = 1'b1;
                res.live_flag     = ((f & LIVE_MASK) != 0);
                res.service_known = (res.stream_kind == sfpc_pkg::KIND_CHUNK);
            end
        end
        return res;
    endfunction

    // Advance the predicted state by one accepted request
    task automatic track_request(input sfpc_pkg::t_in_req r);
        logic [7:0] c;
        int i, k, n;
        bit hit;
        if (r.field_start) begin
            for (k = 0; k < WIN; k++) win_bytes[k] = 8'h00;
            win_fill = 0;
        end
        if (r.carries_char) begin
            c = r.char_code;
            if (c >= 8'h41 && c <= 8'h5a) c = c + 8'h20;
            for (k = WIN - 1; k > 0; k--) win_bytes[k] = win_bytes[k-1];
            win_bytes[0] = c;
            if (win_fill < WIN) win_fill++;
            for (i = 0; i < NPAT; i++) begin
                n = pat_len(i);
                if (pat_field(i) == r.action && win_fill >= n) begin
                    hit = 1'b1;
                    for (k = 0; k < n; k++)
                        if (win_bytes[k] != PTXT[i][8*k +: 8]) hit = 1'b0;
                    if (hit) hit_flags[i] = 1'b1;
                end
            end
        end
        if (r.end_of_flow) begin
            pending_results.insert(pending_results.size(),
                                   classify_flags(r.already_stream, hit_flags));
            hit_flags = '0;
        end
    endtask

    function automatic sfpc_pkg::t_in_req mk_req(input logic [7:0] c, input logic carries,
                                                 input logic [1:0] act, input logic start,
                                                 input logic prior, input logic eof);
        sfpc_pkg::t_in_req r;
        r.char_code      = c;
        r.carries_char   = carries;
        r.action         = act;
        r.field_start    = start;
        r.already_stream = prior;
        r.end_of_flow    = eof;
        return r;
    endfunction

    function automatic logic [7:0] filler_byte(input bit noisy);
        string pool;
        pool = "abcdefghijklmnopqrstuvwxyz0123456789./:-+ABCXYZ";
        if (noisy) return 8'($urandom_range(255));
        return pool[$urandom_range(pool.len() - 1)];
    endfunction

    // Offer one request and hold it until accepted
    task automatic send_req(input sfpc_pkg::t_in_req r);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= r;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        track_request(r);
        sent_count++;
    endtask

    task automatic send_text(input string s, input logic [1:0] act, input bit start,
                             input bit eof, input bit prior);
        int k;
        for (k = 0; k < s.len(); k++)
            send_req(mk_req(s[k], 1'b1, act, start && k == 0, prior && k == s.len() - 1,
                            eof && k == s.len() - 1));
    endtask

    // Drop valid and wait for every pending result, bounded
    task automatic drain_results(input int max_cycles);
        int n;
        n = 0;
        i_in_valid <= 1'b0;
        do begin
            @(posedge i_clk);
            n++;
        end while (pending_results.size() != 0 && n < max_cycles);
        if (pending_results.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, pending_results.size());
            errors++;
            pending_results.delete();
        end
    endtask

    // One flow of fields built to reach the given kind, with random filler and case
    task automatic send_flow(input int target);
        int codes [$];
        int j, k, code, tmp, pick, n;
        logic [1:0] act;
        logic [7:0] text [$];
        logic [7:0] b;
        bit noisy, start, prior, eof_sent, last;
        noisy    = ($urandom_range(4) == 0);
        prior    = ($urandom_range(6) == 0);
        eof_sent = 1'b0;
        case (target)
            sfpc_pkg::KIND_HLS:   codes.insert(codes.size(), $urandom_range(1) ? 0 : 16);
            sfpc_pkg::KIND_DASH:  codes.insert(codes.size(), $urandom_range(1) ? 1 : 17);
            sfpc_pkg::KIND_CHUNK: begin
                codes.insert(codes.size(), CHUNK_HOST_PAT);
                codes.insert(codes.size(), CHUNK_URL_PAT);
            end
            sfpc_pkg::KIND_RTC: begin
                pick = $urandom_range(3);
                codes.insert(codes.size(), pick == 3 ? 20 : 3 + pick);
            end
            sfpc_pkg::KIND_MEDIA: begin
                codes.insert(codes.size(), $urandom_range(NPAT - 1, HOST_BASE));
                codes.insert(codes.size(), $urandom_range(1) ? $urandom_range(15, 11)
                                                             : $urandom_range(19, 18));
            end
            default: ;
        endcase
        if ($urandom_range(2) == 0) codes.insert(codes.size(), $urandom_range(10, 6));
        repeat ($urandom_range(2)) begin
            act = 2'($urandom_range(3));
            if ($urandom_range(1)) begin
                case (act)
                    sfpc_pkg::FIELD_URL:
                        codes.insert(codes.size(), $urandom_range(15));
                    sfpc_pkg::FIELD_CTYPE:
                        codes.insert(codes.size(), $urandom_range(19, 16));
                    sfpc_pkg::FIELD_HDR:
                        codes.insert(codes.size(), 20);
                    default:
                        codes.insert(codes.size(), $urandom_range(NPAT - 1, HOST_BASE));
                endcase
            end else begin
                codes.insert(codes.size(), -1 - int'(act));
            end
        end
        if (codes.size() == 0) codes.insert(0, -1 - int'($urandom_range(3)));
        for (j = codes.size() - 1; j > 0; j--) begin
            k = $urandom_range(j);
            tmp = codes[j];
            codes[j] = codes[k];
            codes[k] = tmp;
        end
        for (j = 0; j < codes.size(); j++) begin
            code = codes[j];
            act  = (code >= 0) ? pat_field(code) : 2'(-1 - code);
            text.delete();
            repeat ($urandom_range(2)) text.insert(text.size(), filler_byte(noisy));
            if (code >= 0) begin
                n = pat_len(code);
                for (k = 0; k < n; k++) begin
                    b = PTXT[code][8*(n - 1 - k) +: 8];
                    if (b >= 8'h61 && b <= 8'h7a && $urandom_range(3) == 0) b = b - 8'h20;
                    text.insert(text.size(), b);
                end
            end
            repeat ($urandom_range(1)) text.insert(text.size(), filler_byte(noisy));
            // now and then leave out the field start, or put it on an empty request
            start = ($urandom_range(9) != 0);
            if (start && $urandom_range(9) == 0) begin
                send_req(mk_req(8'($urandom_range(255)), 1'b0, act, 1'b1,
                                1'($urandom_range(1)), 1'b0));
                start = 1'b0;
            end
            for (k = 0; k < text.size(); k++) begin
                last = (j == codes.size() - 1) && (k == text.size() - 1) && $urandom_range(1);
                send_req(mk_req(text[k], 1'b1, act, start && k == 0,
                                last ? prior : 1'($urandom_range(1)), last));
                if (last) eof_sent = 1'b1;
            end
        end
        if (!eof_sent)
            send_req(mk_req(8'($urandom_range(255)), 1'b0, 2'($urandom_range(3)),
                            $urandom_range(3) == 0, prior, 1'b1));
    endtask

    task automatic send_noise(input int count);
        repeat (count)
            send_req(mk_req(8'($urandom_range(255)), 1'($urandom_range(1)),
                            2'($urandom_range(3)), 1'($urandom_range(1)),
                            1'($urandom_range(1)), $urandom_range(7) == 0));
    endtask

    task automatic test_uppercase_hls();
        send_text(".M3U8", sfpc_pkg::FIELD_URL, 1'b1, 1'b1, 1'b0);
    endtask

    task automatic test_tagged_empty_marker();
        send_req(mk_req(8'h00, 1'b0, sfpc_pkg::FIELD_HOST, 1'b1, 1'b1, 1'b1));
    endtask

    // Byte extremes and bytes just beyond the letter ranges, then a header pattern in capitals
    task automatic test_byte_extremes();
        send_req(mk_req(8'h00, 1'b1, sfpc_pkg::FIELD_HDR, 1'b1, 1'b0, 1'b0));
        send_req(mk_req(8'hff, 1'b1, sfpc_pkg::FIELD_HDR, 1'b0, 1'b0, 1'b0));
        send_req(mk_req(8'h40, 1'b1, sfpc_pkg::FIELD_HDR, 1'b0, 1'b0, 1'b0));
        send_req(mk_req(8'h5b, 1'b1, sfpc_pkg::FIELD_HDR, 1'b0, 1'b0, 1'b0));
        send_req(mk_req(8'h60, 1'b1, sfpc_pkg::FIELD_HDR, 1'b0, 1'b0, 1'b0));
        send_req(mk_req(8'h7b, 1'b1, sfpc_pkg::FIELD_HDR, 1'b0, 1'b0, 1'b0));
        send_text("ICE", sfpc_pkg::FIELD_HDR, 1'b0, 1'b1, 1'b0);
    endtask

    task automatic test_empty_no_detection();
        send_req(mk_req(8'h00, 1'b0, sfpc_pkg::FIELD_URL, 1'b0, 1'b0, 1'b1));
    endtask

    // Window runs on from content type into URL when the start is missing
    task automatic test_missing_field_start();
        send_text("sT", sfpc_pkg::FIELD_CTYPE, 1'b1, 1'b0, 1'b0);
        send_text("uN", sfpc_pkg::FIELD_URL, 1'b0, 1'b1, 1'b0);
    endtask

    task automatic test_random_phase(input int idle_pct, input int stall_pct, input int count);
        int goal;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        goal = sent_count + count;
        while (sent_count < goal) begin
            if ($urandom_range(4) == 0)
                send_noise($urandom_range(12, 3));
            else
                send_flow($urandom_range(sfpc_pkg::KIND_MEDIA));
        end
    endtask

    // Hold the receiver off so that a second end of flow blocks the sender
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 250;
        repeat (5) send_flow($urandom_range(sfpc_pkg::KIND_MEDIA, sfpc_pkg::KIND_HLS));
        drain_results(5000);
        repeat (3) send_flow($urandom_range(sfpc_pkg::KIND_MEDIA));
    endtask

    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result stream=%0b kind=%0d live=%0b svc=%0b",
                             $time, o_out_res.is_stream, o_out_res.stream_kind,
                             o_out_res.live_flag, o_out_res.service_known);
                    errors++;
                end else begin
                    got_want = pending_results.pop_front();
                    if (o_out_res !== got_want) begin
                        $display("%0t: expected %0b/%0d/%0b/%0b, actual %0b/%0d/%0b/%0b",
                                 $time, got_want.is_stream, got_want.stream_kind,
                                 got_want.live_flag, got_want.service_known,
                                 o_out_res.is_stream, o_out_res.stream_kind,
                                 o_out_res.live_flag, o_out_res.service_known);
                        errors++;
                    end
                end
            end
        end
    end

    initial begin
        for (int k = 0; k < WIN; k++) win_bytes[k] = 8'h00;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_uppercase_hls();
        test_tagged_empty_marker();
        test_byte_extremes();
        test_empty_no_detection();
        test_missing_field_start();
        test_random_phase(0, 0, 150);
        test_random_phase(46, 0, 150);
        test_random_phase(0, 46, 150);
        test_random_phase(37, 37, 150);
        test_backpressure();
        recv_stall_pct = 0;
        drain_results(5000);
        repeat (8) @(posedge i_clk);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
